[design/necir_pkg.sv]
// ----------------------------------------------------------------------------
// necir_pkg: shared types and constants for the NEC IR edge capture decoder
// Holds the payload structs, register indexes, timing windows and the
// pulse check result bundle.
// ----------------------------------------------------------------------------
package necir_pkg;

   // Request kinds
   localparam logic REQ_EDGE = 1'b0;
   localparam logic REQ_POLL = 1'b1;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_GLITCH_MIN = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_GAP  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_LONG_PULSE = 2'd2;

   // Register widths and reset values
   localparam int unsigned GLITCH_W = 16;
   localparam int unsigned GAP_W    = 20;
   localparam logic [GLITCH_W-1:0] GLITCH_MIN_RESET = 16'd300;
   localparam logic [GAP_W-1:0]    FRAME_GAP_RESET  = 20'd40000;
   localparam logic [GAP_W-1:0]    LONG_PULSE_RESET = 20'd60000;

   // Pulse count cap default
   localparam int unsigned MAX_PULSE_COUNT_DEFAULT = 200;

   // Timing windows in microseconds, bounds exclusive
   localparam logic [31:0] HDR_LOW_LO  = 32'd8500;
   localparam logic [31:0] HDR_LOW_HI  = 32'd9500;
   localparam logic [31:0] HDR_HIGH_LO = 32'd4000;
   localparam logic [31:0] HDR_HIGH_HI = 32'd5000;
   localparam logic [31:0] SHORT_LO    = 32'd400;
   localparam logic [31:0] SHORT_HI    = 32'd700;
   localparam logic [31:0] LONG_LO     = 32'd1500;
   localparam logic [31:0] LONG_HI     = 32'd2000;

   typedef struct packed {
      logic        req_type;
      logic        edge_falling;
      logic [31:0] time_us;
   } necir_req_type;

   typedef struct packed {
      logic       frame_ok;
      logic [7:0] address;
      logic [7:0] command;
   } necir_rsp_type;

   // Verdict on one recorded pulse
   typedef struct packed {
      logic set_error;
      logic low_ok_load;
      logic low_ok_value;
      logic shift_en;
      logic shift_bit;
   } necir_check_type;

   function automatic logic in_window(input logic [31:0] d,
                                      input logic [31:0] lo,
                                      input logic [31:0] hi);
      return (d > lo) && (d < hi);
   endfunction

endpackage

[design/nec_ir_edge_capture_decoder_core.sv]
// ----------------------------------------------------------------------------
// nec_ir_edge_capture_decoder_core: NEC IR frame decoder on timestamped edges
// Path: a poll that ends a frame is loaded into the input register on accept,
//   then the frame state update loads the result register; the input register
//   holds while a stalled result waits.
// Throughput: 1 transaction per cycle while the result is not stalled; the
//   frame state update is one 32-bit subtract, window compares and a shift.
// Reset: synchronous, active high; clears the frame state and pipeline
//   valids and loads the register defaults. No clearing pass.
// ----------------------------------------------------------------------------
module nec_ir_edge_capture_decoder_core #(
   parameter int unsigned MAX_PULSE_COUNT = necir_pkg::MAX_PULSE_COUNT_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  necir_pkg::necir_req_type              req_data,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output necir_pkg::necir_rsp_type              rsp_data,
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [necir_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [31:0]                           csr_data
);
   import necir_pkg::*;

   localparam int unsigned CNT_W = $clog2(MAX_PULSE_COUNT + 1);

   // Configuration registers
   logic [GLITCH_W-1:0] glitch_min_ff;
   logic [GAP_W-1:0]    frame_gap_ff;
   logic [GAP_W-1:0]    long_pulse_ff;

   // Input stage
   logic          stage_valid_ff, stage_valid_in;
   necir_req_type stage_data_ff;

   // Frame state
   logic             started_ff, started_in;
   logic             level_ff, level_in;
   logic [31:0]      last_time_ff, last_time_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             error_ff, error_in;
   logic             low_ok_ff, low_ok_in;
   logic [31:0]      shift_ff, shift_in;

   // Result register
   logic          rsp_valid_ff, rsp_valid_in;
   necir_rsp_type rsp_data_ff, rsp_data_in;

   logic            advance;
   logic            accept;
   logic            process;
   logic [31:0]     delta;
   logic            fire;
   logic            frame_ok;
   logic            record;
   necir_check_type verdict;

   assign advance   = !(rsp_valid_ff && rsp_stall);
   assign req_stall = stage_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;
   assign process   = stage_valid_ff && advance;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign delta    = stage_data_ff.time_us - last_time_ff;
   assign fire     = process && (stage_data_ff.req_type == REQ_POLL)
                     && (count_ff > CNT_W'(3)) && (delta > 32'(frame_gap_ff));
   assign frame_ok = !error_ff && (shift_ff[7:0] == ~shift_ff[15:8])
                     && (shift_ff[23:16] == ~shift_ff[31:24]);
   assign record   = (count_ff < CNT_W'(MAX_PULSE_COUNT)) && (delta < 32'(long_pulse_ff));

   necir_pulse_check #(
      .CNT_W (CNT_W)
   ) u_pulse_check (
      .pulse_index  (count_ff),
      .level        (level_ff),
      .delta        (delta),
      .low_pulse_ok (low_ok_ff),
      .verdict      (verdict)
   );

   // Hold the input stage until it can advance
   always_comb begin
      stage_valid_in = stage_valid_ff;
      if (accept) begin
         stage_valid_in = 1'b1;
      end else if (advance) begin
         stage_valid_in = 1'b0;
      end
   end

   // Advance the frame state for one transaction
   always_comb begin
      started_in   = started_ff;
      level_in     = level_ff;
      last_time_in = last_time_ff;
      count_in     = count_ff;
      error_in     = error_ff;
      low_ok_in    = low_ok_ff;
      shift_in     = shift_ff;
      if (fire) begin
         started_in   = 1'b0;
         level_in     = 1'b1;
         last_time_in = stage_data_ff.time_us;
         count_in     = '0;
         error_in     = 1'b0;
         low_ok_in    = 1'b0;
         shift_in     = '0;
      end else if (process && (stage_data_ff.req_type == REQ_EDGE)) begin
         if (!started_ff) begin
            started_in   = 1'b1;
            last_time_in = stage_data_ff.time_us;
            level_in     = !stage_data_ff.edge_falling;
         end else if (delta >= 32'(glitch_min_ff)) begin
            last_time_in = stage_data_ff.time_us;
            level_in     = !stage_data_ff.edge_falling;
            if (record) begin
               count_in = count_ff + CNT_W'(1);
               if (verdict.set_error) begin
                  error_in = 1'b1;
               end
               if (verdict.low_ok_load) begin
                  low_ok_in = verdict.low_ok_value;
               end
               if (verdict.shift_en) begin
                  shift_in = {verdict.shift_bit, shift_ff[31:1]};
               end
            end
         end
      end
   end

   // Load the result register on a poll that ends the frame
   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      if (fire) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.frame_ok = frame_ok;
         rsp_data_in.address  = frame_ok ? shift_ff[7:0] : 8'd0;
         rsp_data_in.command  = frame_ok ? shift_ff[23:16] : 8'd0;
      end
   end

   // Control and frame state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         started_ff     <= 1'b0;
         level_ff       <= 1'b1;
         last_time_ff   <= '0;
         count_ff       <= '0;
         error_ff       <= 1'b0;
         low_ok_ff      <= 1'b0;
         shift_ff       <= '0;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
         started_ff     <= started_in;
         level_ff       <= level_in;
         last_time_ff   <= last_time_in;
         count_ff       <= count_in;
         error_ff       <= error_in;
         low_ok_ff      <= low_ok_in;
         shift_ff       <= shift_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         stage_data_ff <= req_data;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // Configuration registers; drop writes to unknown indexes
   always_ff @(posedge clock) begin
      if (reset) begin
         glitch_min_ff <= GLITCH_MIN_RESET;
         frame_gap_ff  <= FRAME_GAP_RESET;
         long_pulse_ff <= LONG_PULSE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GLITCH_MIN: glitch_min_ff <= csr_data[GLITCH_W-1:0];
            CSR_FRAME_GAP:  frame_gap_ff  <= csr_data[GAP_W-1:0];
            CSR_LONG_PULSE: long_pulse_ff <= csr_data[GAP_W-1:0];
            default: ;
         endcase
      end
   end

`ifndef ASSERT_OFF
   a_count_capped: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_PULSE_COUNT))
      else $error("pulse count above cap");

   a_clear_on_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> (count_ff == '0) && !error_ff && (shift_ff == '0) && !started_ff)
      else $error("frame not cleared after result");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      !(fire && rsp_valid_ff && rsp_stall))
      else $error("result overwritten while stalled");

   a_zero_on_fail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.frame_ok) |->
      (rsp_data_ff.address == 8'd0) && (rsp_data_ff.command == 8'd0))
      else $error("failed frame carries data");
`endif

endmodule

[design/necir_pulse_check.sv]
// ----------------------------------------------------------------------------
// necir_pulse_check: judge one recorded pulse
// Classifies the pulse by its position in the frame (header low, header
// high, data low, data high) and reports error, low-pulse flag and bit.
// ----------------------------------------------------------------------------
module necir_pulse_check #(
   parameter int unsigned CNT_W = 8
) (
   input  logic [CNT_W-1:0]          pulse_index,
   input  logic                      level,
   input  logic [31:0]               delta,
   input  logic                      low_pulse_ok,
   output necir_pkg::necir_check_type verdict
);
   import necir_pkg::*;

   logic is_short;
   logic is_long;

   assign is_short = in_window(delta, SHORT_LO, SHORT_HI);
   assign is_long  = in_window(delta, LONG_LO, LONG_HI);

   // Pick the check for this pulse position
   always_comb begin
      verdict = '0;
      if (pulse_index == '0) begin
         verdict.set_error = !(!level && in_window(delta, HDR_LOW_LO, HDR_LOW_HI));
      end else if (pulse_index == CNT_W'(1)) begin
         verdict.set_error = !(level && in_window(delta, HDR_HIGH_LO, HDR_HIGH_HI));
      end else if (!pulse_index[0]) begin
         verdict.low_ok_load  = 1'b1;
         verdict.low_ok_value = !level && is_short;
      end else if (!low_pulse_ok) begin
         verdict.set_error = 1'b1;
      end else if (is_short || is_long) begin
         verdict.shift_en  = 1'b1;
         verdict.shift_bit = is_long;
      end else begin
         verdict.set_error = 1'b1;
      end
   end

endmodule
